// ===== design/s256sh_pkg.sv =====
// Package for the streaming SHA-256 engine: word types, control structures,
// the round constant table and the initial hash values.
// Used by s256sh_dp, s256sh_ctrl and sha256_stream_hash_top; depends on nothing.
package s256sh_pkg;

    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned FILL_W      = 7;
    localparam logic [FILL_W-1:0] FILL_FULL   = 7'd64;
    localparam logic [FILL_W-1:0] FILL_LENGTH = 7'd56;
    localparam logic [31:0] PAD_WORD = 32'h8000_0000;
    localparam logic [2:0]  WORD_BYTES = 3'd4;
    localparam logic [2:0]  LAST_DIGEST_INDEX = 3'd7;

    // One input word: up to four message bytes, first byte in the top bits.
    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  valid_bytes;
        logic        last_item;
    } msg_item_t;

    // One output word of the digest.
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_item_t;

    // Where the bytes of an append come from.
    typedef enum logic [2:0] {
        SRC_MSG   = 3'd0,
        SRC_PAD80 = 3'd1,
        SRC_ZERO  = 3'd2,
        SRC_LENH  = 3'd3,
        SRC_LENL  = 3'd4
    } src_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_item;
        logic       append;
        src_sel_t   src;
        logic       comp_start;
        logic       round;
        logic       comp_end;
        logic       out_load;
        logic       msg_end;
        logic [5:0] cnt;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic fill_at_length;
        logic msg_done;
        logic last_item;
        logic out_free;
    } status_t;

    function automatic logic [31:0] round_const(input logic [5:0] idx);
        logic [31:0] k;
        unique case (idx)
            6'd0:  k = 32'h428a2f98;
            6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;
            6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;
            6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;
            6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;
            6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;
            6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;
            6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;
            6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;
            6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;
            6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;
            6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;
            6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;
            6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;
            6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;
            6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;
            6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;
            6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;
            6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;
            6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;
            6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;
            6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;
            6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;
            6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;
            6'd63: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] init_hash(input logic [2:0] idx);
        logic [31:0] h;
        unique case (idx)
            3'd0: h = 32'h6a09e667;
            3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372;
            3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f;
            3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab;
            3'd7: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

endpackage

// ===== design/s256sh_dp.sv =====
// Datapath of the streaming SHA-256 engine: block shift register, fill and
// byte counters, chaining value, round registers and the output register.
// Depends on s256sh_pkg; driven by commands from s256sh_ctrl.
module s256sh_dp (
    input  logic                     clk,
    input  logic                     rst_n,
    input  s256sh_pkg::msg_item_t    msg,
    input  s256sh_pkg::cmd_t         cmd,
    output s256sh_pkg::status_t      status,
    input  logic                     digest_stall,
    output logic                     digest_valid,
    output s256sh_pkg::digest_item_t digest
);

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    // The block is a byte shift line: new bytes enter at the bottom, so after
    // sixty-four bytes the first byte sits in the top byte. During the rounds
    // the same register shifts by one word per cycle as the schedule window.
    logic [511:0]                  blk_reg, blk_next, blk_shifted;
    logic [s256sh_pkg::FILL_W-1:0] fill_reg, fill_next;
    logic [63:0]                   total_reg, total_next;
    logic [31:0]                   pend_word_reg, pend_word_next, pend_shifted;
    logic [2:0]                    pend_cnt_reg, pend_cnt_next;
    logic                          last_reg, last_next;
    logic [7:0][31:0]              h_reg, h_next;
    logic [7:0][31:0]              v_reg, v_next;
    s256sh_pkg::digest_item_t      out_reg, out_next;
    logic                          out_valid_reg, out_valid_next;

    logic [s256sh_pkg::FILL_W-1:0] space, zero_target, zero_gap;
    logic [2:0]                    msg_n, zero_n, app_n, cnt_sat;
    logic [31:0]                   src_word;
    logic [63:0]                   len_bits;
    logic [31:0]                   w_t, w_new, t1, t2, ch, maj;

    assign cnt_sat  = (msg.valid_bytes > s256sh_pkg::WORD_BYTES) ?
                      s256sh_pkg::WORD_BYTES : msg.valid_bytes;
    assign space    = s256sh_pkg::FILL_FULL - fill_reg;
    assign msg_n    = ({4'b0, pend_cnt_reg} <= space) ? pend_cnt_reg : space[2:0];
    assign zero_target = (fill_reg > s256sh_pkg::FILL_LENGTH) ?
                         s256sh_pkg::FILL_FULL : s256sh_pkg::FILL_LENGTH;
    assign zero_gap = zero_target - fill_reg;
    assign zero_n   = (zero_gap > 7'd4) ? s256sh_pkg::WORD_BYTES : zero_gap[2:0];
    assign len_bits = {total_reg[60:0], 3'b000};

    always_comb
    begin
        case (cmd.src)
            s256sh_pkg::SRC_MSG:
            begin
                src_word = pend_word_reg;
                app_n    = msg_n;
            end
            s256sh_pkg::SRC_PAD80:
            begin
                src_word = s256sh_pkg::PAD_WORD;
                app_n    = 3'd1;
            end
            s256sh_pkg::SRC_ZERO:
            begin
                src_word = 32'h0;
                app_n    = zero_n;
            end
            s256sh_pkg::SRC_LENH:
            begin
                src_word = len_bits[63:32];
                app_n    = s256sh_pkg::WORD_BYTES;
            end
            s256sh_pkg::SRC_LENL:
            begin
                src_word = len_bits[31:0];
                app_n    = s256sh_pkg::WORD_BYTES;
            end
            default:
            begin
                src_word = 32'h0;
                app_n    = 3'd0;
            end
        endcase
    end

    always_comb
    begin
        case (app_n)
            3'd0:    blk_shifted = blk_reg;
            3'd1:    blk_shifted = {blk_reg[503:0], src_word[31:24]};
            3'd2:    blk_shifted = {blk_reg[495:0], src_word[31:16]};
            3'd3:    blk_shifted = {blk_reg[487:0], src_word[31:8]};
            default: blk_shifted = {blk_reg[479:0], src_word};
        endcase
        case (msg_n)
            3'd0:    pend_shifted = pend_word_reg;
            3'd1:    pend_shifted = {pend_word_reg[23:0], 8'h0};
            3'd2:    pend_shifted = {pend_word_reg[15:0], 16'h0};
            3'd3:    pend_shifted = {pend_word_reg[7:0], 24'h0};
            default: pend_shifted = 32'h0;
        endcase
    end

    // One round and one schedule step per cycle.
    assign w_t   = blk_reg[511:480];
    assign w_new = ssig1(blk_reg[63:32]) + blk_reg[223:192] + ssig0(blk_reg[479:448]) + w_t;
    assign ch    = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign maj   = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1    = v_reg[7] + bsig1(v_reg[4]) + ch + s256sh_pkg::round_const(cmd.cnt) + w_t;
    assign t2    = bsig0(v_reg[0]) + maj;

    always_comb
    begin
        fill_next      = fill_reg;
        total_next     = total_reg;
        pend_word_next = pend_word_reg;
        pend_cnt_next  = pend_cnt_reg;
        last_next      = last_reg;
        blk_next       = blk_reg;
        v_next         = v_reg;
        h_next         = h_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && digest_stall;

        if (cmd.load_item)
        begin
            pend_word_next = msg.data_word;
            pend_cnt_next  = cnt_sat;
            last_next      = msg.last_item;
            total_next     = total_reg + {61'b0, cnt_sat};
        end
        if (cmd.append)
        begin
            blk_next  = blk_shifted;
            fill_next = fill_reg + {4'b0, app_n};
            if (cmd.src == s256sh_pkg::SRC_MSG)
            begin
                pend_word_next = pend_shifted;
                pend_cnt_next  = pend_cnt_reg - msg_n;
            end
        end
        if (cmd.comp_start)
        begin
            v_next = h_reg;
        end
        if (cmd.round)
        begin
            v_next[7] = v_reg[6];
            v_next[6] = v_reg[5];
            v_next[5] = v_reg[4];
            v_next[4] = v_reg[3] + t1;
            v_next[3] = v_reg[2];
            v_next[2] = v_reg[1];
            v_next[1] = v_reg[0];
            v_next[0] = t1 + t2;
            blk_next  = {blk_reg[479:0], w_new};
        end
        if (cmd.comp_end)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_next[i] = h_reg[i] + v_reg[i];
            end
            fill_next = '0;
        end
        if (cmd.out_load)
        begin
            out_next.digest_word = h_reg[cmd.cnt[2:0]];
            out_next.word_index  = cmd.cnt[2:0];
            out_next.last_word   = (cmd.cnt[2:0] == s256sh_pkg::LAST_DIGEST_INDEX);
            out_valid_next       = 1'b1;
        end
        if (cmd.msg_end)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_next[i] = s256sh_pkg::init_hash(3'(i));
            end
            fill_next  = '0;
            total_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            total_reg     <= '0;
            pend_cnt_reg  <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= s256sh_pkg::init_hash(3'(i));
            end
        end
        else
        begin
            fill_reg      <= fill_next;
            total_reg     <= total_next;
            pend_cnt_reg  <= pend_cnt_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
            h_reg         <= h_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg       <= blk_next;
        pend_word_reg <= pend_word_next;
        v_reg         <= v_next;
        out_reg       <= out_next;
    end

    assign status.full           = (fill_reg == s256sh_pkg::FILL_FULL);
    assign status.fill_at_length = (fill_reg == s256sh_pkg::FILL_LENGTH);
    assign status.msg_done       = ({4'b0, pend_cnt_reg} <= space);
    assign status.last_item      = last_reg;
    assign status.out_free       = !out_valid_reg || !digest_stall;

    assign digest_valid = out_valid_reg;
    assign digest       = out_reg;

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= s256sh_pkg::FILL_FULL)
        else $error("block fill count above one block");

    a_pend_range: assert property (@(posedge clk) disable iff (!rst_n)
        pend_cnt_reg <= s256sh_pkg::WORD_BYTES)
        else $error("pending byte count above one word");

    a_comp_end_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.comp_end |-> fill_reg == s256sh_pkg::FILL_FULL)
        else $error("compression finished on a block that was not full");

endmodule

// ===== design/s256sh_ctrl.sv =====
// Controller of the streaming SHA-256 engine: one-hot state machine that
// sequences byte appends, padding, the 64 rounds and the digest read-out.
// Depends on s256sh_pkg; drives s256sh_dp through cmd_t and reads status_t.
module s256sh_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                msg_valid,
    output logic                msg_stall,
    input  s256sh_pkg::status_t status,
    output s256sh_pkg::cmd_t    cmd
);

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b00_0000_0001,
        ST_MSG   = 10'b00_0000_0010,
        ST_P80   = 10'b00_0000_0100,
        ST_ZERO  = 10'b00_0000_1000,
        ST_LENH  = 10'b00_0001_0000,
        ST_LENL  = 10'b00_0010_0000,
        ST_DONE  = 10'b00_0100_0000,
        ST_ROUND = 10'b00_1000_0000,
        ST_CUPD  = 10'b01_0000_0000,
        ST_OUT   = 10'b10_0000_0000
    } state_t;

    state_t     state_reg, state_next;
    state_t     ret_reg, ret_next;
    logic [5:0] cnt_reg, cnt_next;

    always_comb
    begin
        cmd        = '0;
        cmd.src    = s256sh_pkg::SRC_MSG;
        cmd.cnt    = cnt_reg;
        state_next = state_reg;
        ret_next   = ret_reg;
        cnt_next   = cnt_reg;
        msg_stall  = (state_reg != ST_IDLE);

        unique case (state_reg) inside
            ST_IDLE:
            begin
                if (msg_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_MSG;
                end
            end
            ST_MSG, ST_P80, ST_ZERO, ST_DONE:
            begin
                if (status.full)
                begin
                    // A full block is compressed before anything else moves.
                    cmd.comp_start = 1'b1;
                    ret_next       = state_reg;
                    cnt_next       = '0;
                    state_next     = ST_ROUND;
                end
                else if (state_reg == ST_MSG)
                begin
                    cmd.append = 1'b1;
                    cmd.src    = s256sh_pkg::SRC_MSG;
                    if (status.msg_done)
                    begin
                        state_next = status.last_item ? ST_P80 : ST_IDLE;
                    end
                end
                else if (state_reg == ST_P80)
                begin
                    cmd.append = 1'b1;
                    cmd.src    = s256sh_pkg::SRC_PAD80;
                    state_next = ST_ZERO;
                end
                else if (state_reg == ST_ZERO)
                begin
                    if (status.fill_at_length)
                    begin
                        state_next = ST_LENH;
                    end
                    else
                    begin
                        cmd.append = 1'b1;
                        cmd.src    = s256sh_pkg::SRC_ZERO;
                    end
                end
                else
                begin
                    cnt_next   = '0;
                    state_next = ST_OUT;
                end
            end
            ST_LENH:
            begin
                cmd.append = 1'b1;
                cmd.src    = s256sh_pkg::SRC_LENH;
                state_next = ST_LENL;
            end
            ST_LENL:
            begin
                cmd.append = 1'b1;
                cmd.src    = s256sh_pkg::SRC_LENL;
                state_next = ST_DONE;
            end
            ST_ROUND:
            begin
                cmd.round = 1'b1;
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    state_next = ST_CUPD;
                end
            end
            ST_CUPD:
            begin
                cmd.comp_end = 1'b1;
                state_next   = ret_reg;
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cnt_next     = cnt_reg + 6'd1;
                    if (cnt_reg[2:0] == s256sh_pkg::LAST_DIGEST_INDEX)
                    begin
                        cmd.msg_end = 1'b1;
                        cnt_next    = '0;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.append |-> !status.full)
        else $error("append issued into a full block");

    a_cupd_clears: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CUPD |=> !status.full)
        else $error("block still full after compression");

    a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("digest word loaded over an unread word");

    a_accept_to_msg: assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && !msg_stall |=> state_reg == ST_MSG)
        else $error("accepted word not taken into the append step");

endmodule

// ===== design/sha256_stream_hash_top.sv =====
// Streaming SHA-256 engine, top level. A non-final word is accepted, then
// appended; each full 64-byte block is then compressed by the single shared
// round unit (one round per cycle), while msg_stall holds off further words.
// After the final word the padding is appended, spilling into an extra block
// when needed, and the eight digest words then follow.
// Reset (rst_n, asynchronous, active low) loads the initial hash values.
module sha256_stream_hash_top (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     msg_valid,
    output logic                     msg_stall,
    input  s256sh_pkg::msg_item_t    msg,
    output logic                     digest_valid,
    input  logic                     digest_stall,
    output s256sh_pkg::digest_item_t digest
);

    // The controller decides what happens each cycle; the datapath holds all
    // message state. They talk only through these two structures.
    s256sh_pkg::cmd_t    cmd;
    s256sh_pkg::status_t status;

    // Sequencing: a word is accepted only in the idle state, its bytes are
    // appended in the append state, and a block that fills is compressed
    // before more bytes go in. The final word triggers the 0x80 byte,
    // zero fill and the 64-bit bit length, then the digest read-out.
    s256sh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg_valid),
        .msg_stall (msg_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath keeps the block as a byte shift line that doubles as the
    // message schedule window, and drives the digest through an output
    // register, so the next message word can be taken while the last digest
    // word still waits downstream.
    s256sh_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg          (msg),
        .cmd          (cmd),
        .status       (status),
        .digest_stall (digest_stall),
        .digest_valid (digest_valid),
        .digest       (digest)
    );

endmodule

// ===== tb/sha256_stream_hash_top_test.sv =====
// Self-checking testbench for sha256_stream_hash_top: drives message words, predicts
// each SHA-256 digest in a model of its own and checks every digest word returned.
// Depends on s256sh_pkg and the sha256_stream_hash_top RTL only.
module sha256_stream_hash_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Run shape. The random part stops once this many words are queued, and the
    // last TAIL_WORDS words go through with no idling on either side.
    localparam int RANDOM_UNTIL = 230;
    localparam int TAIL_WORDS   = 30;
    // The long receiver hold-off starts once HOLD_AT words have gone in.
    localparam int HOLD_AT      = 40;
    localparam int HOLD_CYCLES  = 800;
    // Run-out once no digest word is owed any more, which leaves ample room
    // for any stray output.
    localparam int DRAIN_CYCLES = 300;
    localparam int REPORT_MAX   = 10;

    localparam bit [31:0] HASH_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam bit [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Every input of the block starts at a known value.
    logic                     clk          = 1'b0;
    logic                     rst_n        = 1'b0;
    logic                     msg_valid    = 1'b0;
    logic                     msg_stall;
    s256sh_pkg::msg_item_t    msg          = '0;
    logic                     digest_valid;
    logic                     digest_stall = 1'b0;
    s256sh_pkg::digest_item_t digest;

    // Words waiting to be offered, and digest words still owed by the block.
    s256sh_pkg::msg_item_t    pending_words [$];
    s256sh_pkg::digest_item_t digest_due [$];

    int words_taken = 0;
    int total_words = 0;
    int bad_count   = 0;
    int send_gap    = 0;
    int stall_left  = 0;
    bit took_word   = 1'b0;
    bit hold_off    = 1'b0;
    logic calm;

    // Our own copy of the hashing state: chaining value, 64-byte block,
    // how far the block is filled and the running byte count.
    bit [31:0] hash_state [8];
    bit [7:0]  blk [64];
    int        blk_fill;
    bit [63:0] msg_bytes;

    sha256_stream_hash_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg_valid    (msg_valid),
        .msg_stall    (msg_stall),
        .msg          (msg),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest       (digest)
    );

    // No idling once the run is into its final stretch.
    assign calm = (words_taken + TAIL_WORDS >= total_words);

    function automatic bit [31:0] rotr(bit [31:0] x, int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void start_digest();
        hash_state = HASH_IV;
        blk_fill   = 0;
        msg_bytes  = '0;
    endfunction

    // One full 64-byte block through the 64 rounds, folded into the chaining value.
    function automatic void compress_block();
        bit [31:0] w [64];
        bit [31:0] v [8];
        bit [31:0] s0;
        bit [31:0] s1;
        bit [31:0] t1;
        bit [31:0] t2;
        for (int i = 0; i < 16; i++)
        begin
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        end
        for (int i = 16; i < 64; i++)
        begin
            s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = s1 + w[i-7] + s0 + w[i-16];
        end
        v = hash_state;
        for (int i = 0; i < 64; i++)
        begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
        begin
            hash_state[i] += v[i];
        end
    endfunction

    function automatic void absorb_byte(bit [7:0] b);
        blk[blk_fill] = b;
        blk_fill++;
        if (blk_fill == 64)
        begin
            compress_block();
            blk_fill = 0;
        end
    endfunction

    // Takes one accepted word. A final word closes the message: the 0x80 marker,
    // zero padding (spilling into an extra block when the marker lands past
    // byte 56) and the 64-bit bit length, after which the eight digest words
    // are owed and the state starts afresh.
    function automatic void hash_word(s256sh_pkg::msg_item_t item);
        int unsigned              n;
        bit [63:0]                bits;
        s256sh_pkg::digest_item_t d;
        n = (item.valid_bytes > s256sh_pkg::WORD_BYTES) ?
            s256sh_pkg::WORD_BYTES : item.valid_bytes;
        for (int i = 0; i < n; i++)
        begin
            absorb_byte(item.data_word[31 - 8*i -: 8]);
        end
        msg_bytes += 64'(n);
        if (!item.last_item)
            return;
        bits = msg_bytes << 3;
        absorb_byte(8'h80);
        if (blk_fill > 56)
        begin
            while (blk_fill != 0)
                absorb_byte(8'h00);
        end
        while (blk_fill < 56)
            absorb_byte(8'h00);
        for (int i = 0; i < 8; i++)
        begin
            absorb_byte(bits[63 - 8*i -: 8]);
        end
        for (int i = 0; i < 8; i++)
        begin
            d.digest_word = hash_state[i];
            d.word_index  = 3'(i);
            d.last_word   = (3'(i) == s256sh_pkg::LAST_DIGEST_INDEX);
            digest_due.push_back(d);
        end
        start_digest();
    endfunction

    function automatic void queue_word(bit [31:0] data, bit [2:0] count, bit fin);
        s256sh_pkg::msg_item_t item;
        item.data_word   = data;
        item.valid_bytes = count;
        item.last_item   = fin;
        pending_words.push_back(item);
    endfunction

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Reset is released at a falling edge, so the
    // release is never seen in the same step as a rising edge.
    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // A word is taken at a rising edge where valid is high and stall is low.
    // The prediction is made at that moment, in the order the block sees words.
    always @(posedge clk)
    begin
        took_word <= rst_n && msg_valid && !msg_stall;
        if (rst_n && msg_valid && !msg_stall)
        begin
            hash_word(msg);
            words_taken <= words_taken + 1;
        end
    end

    // Sender. A word on offer is held steady until it has been taken; only then
    // may the next one go out or a random gap of idle cycles begin. Gaps are
    // dropped during the long hold-off so that the block is kept busy and has
    // to push back on its input.
    always @(negedge clk)
    begin
        if (rst_n && !(msg_valid && !took_word))
        begin
            if (send_gap != 0)
            begin
                send_gap--;
                msg_valid <= 1'b0;
            end
            else if (pending_words.size() != 0)
            begin
                msg       <= pending_words.pop_front();
                msg_valid <= 1'b1;
                if (!calm && !hold_off && $urandom_range(0, 4) == 0)
                    send_gap = $urandom_range(1, 11);
            end
            else
            begin
                msg_valid <= 1'b0;
            end
        end
    end

    // Receiver. Stall comes in random bursts, or is held for
    // the whole of the long hold-off.
    always @(negedge clk)
    begin : digest_receiver
        bit burst;
        burst = 1'b0;
        if (stall_left != 0)
        begin
            stall_left--;
            burst = 1'b1;
        end
        else if (!calm && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 10);
            burst = 1'b1;
        end
        digest_stall <= burst || hold_off;
    end

    // The long hold-off: counted on rising edges, read by the receiver and the
    // sender at the falling edges in between.
    initial
    begin
        @(posedge clk);
        while (words_taken < HOLD_AT)
            @(posedge clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
    end

    // Each digest word taken is compared field by field with the oldest one
    // owed. A word arriving when nothing is owed is a failure as well.
    always @(posedge clk)
    begin : digest_check
        s256sh_pkg::digest_item_t want;
        if (rst_n && digest_valid && !digest_stall)
        begin
            if (digest_due.size() == 0)
            begin
                if (bad_count < REPORT_MAX)
                    $display("unexpected digest word %h index %0d last %0d",
                             digest.digest_word, digest.word_index, digest.last_word);
                bad_count++;
            end
            else
            begin
                want = digest_due.pop_front();
                if (digest.digest_word !== want.digest_word
                    || digest.word_index !== want.word_index
                    || digest.last_word !== want.last_word)
                begin
                    if (bad_count < REPORT_MAX)
                        $display("digest mismatch: expected %h/%0d/%0d, got %h/%0d/%0d",
                                 want.digest_word, want.word_index, want.last_word,
                                 digest.digest_word, digest.word_index, digest.last_word);
                    bad_count++;
                end
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int len;
        int pick;
        start_digest();

        // Directed words. An empty message, whose payload must be ignored.
        queue_word(32'hffff_ffff, 3'd0, 1'b1);
        // The three-byte message "abc"; the low byte is not part of it.
        queue_word(32'h6162_63ff, 3'd3, 1'b1);
        // A message with a count above four (taken as four), a short word in the
        // middle that the rest of the message simply follows, and a final word
        // that again claims more than four bytes.
        queue_word(32'hffff_ffff, 3'd4, 1'b0);
        queue_word(32'h0000_0000, 3'd7, 1'b0);
        queue_word(32'ha5ff_ffff, 3'd1, 1'b0);
        queue_word(32'h5a5a_5a5a, 3'd4, 1'b0);
        queue_word(32'h8000_0001, 3'd6, 1'b1);
        // Exactly 56 bytes and an empty final word: the marker lands in the
        // length field, so the padding spills into a second block.
        for (int i = 0; i < 14; i++)
            queue_word($urandom, (i == 3) ? 3'd5 : (i == 9) ? 3'd6 : 3'd4, 1'b0);
        queue_word($urandom, 3'd0, 1'b1);

        // Random messages, mostly short, some spanning several blocks. Now and
        // then a word mid-message carries fewer (or nominally more) than four bytes.
        while (pending_words.size() < RANDOM_UNTIL)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 14)
                len = $urandom_range(0, 15);
            else if (pick < 19)
                len = $urandom_range(16, 31);
            else
                len = $urandom_range(32, 48);
            repeat (len)
            begin
                if ($urandom_range(0, 9) == 0)
                    queue_word($urandom, 3'($urandom_range(0, 7)), 1'b0);
                else
                    queue_word($urandom, s256sh_pkg::WORD_BYTES, 1'b0);
            end
            queue_word($urandom, 3'($urandom_range(0, 7)), 1'b1);
        end
        total_words = pending_words.size();

        do
            @(negedge clk);
        while (words_taken < total_words || digest_due.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (bad_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // A correct run takes some tens of microseconds; this allows many times that.
    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
design/s256sh_pkg.sv
design/s256sh_dp.sv
design/s256sh_ctrl.sv
design/sha256_stream_hash_top.sv
tb/sha256_stream_hash_top_test.sv
